[design/osm_pkg.sv]
// ----------------------------------------------------------------------------
// osm_pkg
// shared types, codes and helpers for the one-shot modifier block
// ----------------------------------------------------------------------------
package osm_pkg;

  // field widths
  localparam int unsigned KeyCodeW  = 16;
  localparam int unsigned ActionW   = 2;
  localparam int unsigned ModeCodeW = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 16;

  // configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_TRIGGER_CODE  = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_MODIFIER_CODE = 2'd1;
  localparam logic [CfgIndexW-1:0] CFG_LOCK_ENABLE   = 2'd2;

  // external mode codes as reported on the result channel
  localparam logic [ModeCodeW-1:0] CODE_UP          = 3'd0;
  localparam logic [ModeCodeW-1:0] CODE_QUEUED      = 3'd1;
  localparam logic [ModeCodeW-1:0] CODE_QUEUED_USED = 3'd2;
  localparam logic [ModeCodeW-1:0] CODE_DOWN_UNUSED = 3'd3;
  localparam logic [ModeCodeW-1:0] CODE_DOWN_USED   = 3'd4;
  localparam logic [ModeCodeW-1:0] CODE_LOCKED      = 3'd5;

  // modifier action codes
  typedef enum logic [ActionW-1:0] {
    ACT_NONE  = 2'd0,
    ACT_REG   = 2'd1,
    ACT_UNREG = 2'd2
  } action_t;

  // one-shot mode, one-hot
  typedef enum logic [5:0] {
    MODE_UP          = 6'b000001,
    MODE_QUEUED      = 6'b000010,
    MODE_QUEUED_USED = 6'b000100,
    MODE_DOWN_UNUSED = 6'b001000,
    MODE_DOWN_USED   = 6'b010000,
    MODE_LOCKED      = 6'b100000
  } mode_t;

  // one key event
  typedef struct packed {
    logic [KeyCodeW-1:0] key_code;
    logic                key_pressed;
    logic                cancel_key;
    logic                ignored_key;
  } key_event_t;

  // configuration seen by the step logic
  typedef struct packed {
    logic [KeyCodeW-1:0] trigger_code;
    logic                lock_enable;
  } step_cfg_t;

  // result of one step
  typedef struct packed {
    mode_t   mode_next;
    action_t action;
  } step_res_t;

  // one-hot mode to reported code
  function automatic logic [ModeCodeW-1:0] mode_code(input mode_t m);
    logic [ModeCodeW-1:0] c;
    case (m)
      MODE_UP:          c = CODE_UP;
      MODE_QUEUED:      c = CODE_QUEUED;
      MODE_QUEUED_USED: c = CODE_QUEUED_USED;
      MODE_DOWN_UNUSED: c = CODE_DOWN_UNUSED;
      MODE_DOWN_USED:   c = CODE_DOWN_USED;
      MODE_LOCKED:      c = CODE_LOCKED;
      default:          c = CODE_UP;
    endcase
    return c;
  endfunction

endpackage

[design/osm_if.sv]
// ----------------------------------------------------------------------------
// osm_if
// valid/ready channels of the one-shot modifier block
// ----------------------------------------------------------------------------

// key event channel
interface osm_key_if;
  logic                             valid;
  logic                             ready;
  logic [osm_pkg::KeyCodeW-1:0]     key_code;
  logic                             key_pressed;
  logic                             cancel_key;
  logic                             ignored_key;

  modport source (output valid, key_code, key_pressed, cancel_key, ignored_key,
                  input ready);
  modport sink   (input valid, key_code, key_pressed, cancel_key, ignored_key,
                  output ready);
endinterface

// result channel
interface osm_res_if;
  logic                             valid;
  logic                             ready;
  logic [osm_pkg::ActionW-1:0]      mod_action;
  logic [osm_pkg::KeyCodeW-1:0]     mod_keycode;
  logic [osm_pkg::ModeCodeW-1:0]    new_mode;

  modport source (output valid, mod_action, mod_keycode, new_mode, input ready);
  modport sink   (input valid, mod_action, mod_keycode, new_mode, output ready);
endinterface

// configuration write channel
interface osm_cfg_if;
  logic                             valid;
  logic                             ready;
  logic [osm_pkg::CfgIndexW-1:0]    index;
  logic [osm_pkg::CfgDataW-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[design/osm_step.sv]
// ----------------------------------------------------------------------------
// osm_step
// next-mode and action logic for one key event
// ----------------------------------------------------------------------------
module osm_step (
  input  osm_pkg::mode_t      mode,
  input  osm_pkg::key_event_t evt,
  input  osm_pkg::step_cfg_t  cfg,
  output osm_pkg::step_res_t  res
);

  // transition table
  always_comb begin
    osm_pkg::mode_t   m;
    osm_pkg::action_t act;
    m   = mode;
    act = osm_pkg::ACT_NONE;
    if (evt.key_code == cfg.trigger_code) begin
      // trigger key itself
      if (evt.key_pressed) begin
        case (mode)
          osm_pkg::MODE_UP: begin
            m   = osm_pkg::MODE_DOWN_UNUSED;
            act = osm_pkg::ACT_REG;
          end
          osm_pkg::MODE_QUEUED: begin
            m = cfg.lock_enable ? osm_pkg::MODE_LOCKED : osm_pkg::MODE_DOWN_UNUSED;
          end
          osm_pkg::MODE_LOCKED: begin
            m   = osm_pkg::MODE_UP;
            act = osm_pkg::ACT_UNREG;
          end
          default: begin
            m = osm_pkg::MODE_DOWN_UNUSED;
          end
        endcase
      end else begin
        case (mode)
          osm_pkg::MODE_DOWN_UNUSED: begin
            m = osm_pkg::MODE_QUEUED;
          end
          osm_pkg::MODE_DOWN_USED: begin
            m   = osm_pkg::MODE_UP;
            act = osm_pkg::ACT_UNREG;
          end
          default: begin
            m = mode;
          end
        endcase
      end
    end else if (evt.key_pressed) begin
      // other key down: cancel first, then use up a queued one-shot
      if (evt.cancel_key && (mode != osm_pkg::MODE_UP)) begin
        m   = osm_pkg::MODE_UP;
        act = osm_pkg::ACT_UNREG;
      end
      if (!evt.ignored_key) begin
        if (m == osm_pkg::MODE_QUEUED) begin
          m = osm_pkg::MODE_QUEUED_USED;
        end else if (m == osm_pkg::MODE_QUEUED_USED) begin
          m   = osm_pkg::MODE_UP;
          act = osm_pkg::ACT_UNREG;
        end
      end
    end else if (!evt.ignored_key) begin
      // other key up
      case (mode)
        osm_pkg::MODE_DOWN_UNUSED: begin
          m = osm_pkg::MODE_DOWN_USED;
        end
        osm_pkg::MODE_QUEUED, osm_pkg::MODE_QUEUED_USED: begin
          m   = osm_pkg::MODE_UP;
          act = osm_pkg::ACT_UNREG;
        end
        default: begin
          m = mode;
        end
      endcase
    end
    res.mode_next = m;
    res.action    = act;
  end

endmodule

[design/oneshot_modifier_fsm_top.sv]
// ----------------------------------------------------------------------------
// oneshot_modifier_fsm_top
// one-shot modifier key state machine with valid/ready channels
// ----------------------------------------------------------------------------
// Usage:
//   key_in  takes one key event per request: keycode, press/release flag and
//           the cancel and ignored flags worked out by the key matrix logic.
//   mod_out gives exactly one result per event: the modifier action (none,
//           register, unregister), the configured modifier keycode and the
//           mode after the event.
//   cfg     writes trigger_code (0), modifier_code (1) and lock_enable (2);
//           always ready, other indexes are dropped. Write only while idle.
// Timing:
//   the mode update and the result are formed in the cycle an event is
//   taken and sit in the result register in the next cycle; one event per
//   cycle while mod_out does not stall, set by the single mode register loop.
// Reset and stall:
//   rst (synchronous) clears the mode to up, all configuration registers to
//   zero and the result register to empty. While mod_out is stalled with a
//   result held, key_in is not ready; it is ready again in the cycle the
//   result is taken.
// ----------------------------------------------------------------------------
module oneshot_modifier_fsm_top (
  input  logic         clk,
  input  logic         rst,
  osm_cfg_if.sink      cfg,
  osm_key_if.sink      key_in,
  osm_res_if.source    mod_out
);

  logic [osm_pkg::KeyCodeW-1:0]   trigger_code;
  logic [osm_pkg::KeyCodeW-1:0]   modifier_code;
  logic                           lock_enable;
  osm_pkg::mode_t                 mode;
  osm_pkg::key_event_t            evt;
  osm_pkg::step_cfg_t             step_cfg;
  osm_pkg::step_res_t             step_res;
  logic                           accept;
  logic                           res_valid;
  logic [osm_pkg::ActionW-1:0]    res_action;
  logic [osm_pkg::KeyCodeW-1:0]   res_keycode;
  logic [osm_pkg::ModeCodeW-1:0]  res_mode;

  // configuration registers
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      trigger_code  <= '0;
      modifier_code <= '0;
      lock_enable   <= 1'b0;
    end else if (cfg.valid) begin
      case (cfg.index)
        osm_pkg::CFG_TRIGGER_CODE:  trigger_code  <= cfg.data;
        osm_pkg::CFG_MODIFIER_CODE: modifier_code <= cfg.data;
        osm_pkg::CFG_LOCK_ENABLE:   lock_enable   <= cfg.data[0];
        default: ;
      endcase
    end
  end

  // input handshake
  assign key_in.ready = !res_valid || mod_out.ready;
  assign accept       = key_in.valid && key_in.ready;

  assign evt.key_code    = key_in.key_code;
  assign evt.key_pressed = key_in.key_pressed;
  assign evt.cancel_key  = key_in.cancel_key;
  assign evt.ignored_key = key_in.ignored_key;

  assign step_cfg.trigger_code = trigger_code;
  assign step_cfg.lock_enable  = lock_enable;

  // transition logic
  osm_step u_step (
    .mode (mode),
    .evt  (evt),
    .cfg  (step_cfg),
    .res  (step_res)
  );

  // mode register
  always_ff @(posedge clk) begin
    if (rst) begin
      mode <= osm_pkg::MODE_UP;
    end else if (accept) begin
      mode <= step_res.mode_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (accept) begin
      res_valid <= 1'b1;
    end else if (mod_out.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      res_action  <= step_res.action;
      res_keycode <= modifier_code;
      res_mode    <= osm_pkg::mode_code(step_res.mode_next);
    end
  end

  assign mod_out.valid       = res_valid;
  assign mod_out.mod_action  = res_action;
  assign mod_out.mod_keycode = res_keycode;
  assign mod_out.new_mode    = res_mode;

endmodule

[design/osm_checker.sv]
// ----------------------------------------------------------------------------
// osm_checker
// port-level checks on the result channel of the one-shot modifier block
// ----------------------------------------------------------------------------
module osm_checker (
  input logic                           clk,
  input logic                           rst,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic [osm_pkg::ActionW-1:0]    out_action,
  input logic [osm_pkg::KeyCodeW-1:0]   out_keycode,
  input logic [osm_pkg::ModeCodeW-1:0]  out_mode
);

  // reset empties the result register
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // register only ever leads into down unused
  a_reg_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_action == osm_pkg::ACT_REG)) |->
      (out_mode == osm_pkg::CODE_DOWN_UNUSED))
    else $error("register action with wrong mode");

  // unregister always returns to up
  a_unreg_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_action == osm_pkg::ACT_UNREG)) |->
      (out_mode == osm_pkg::CODE_UP))
    else $error("unregister action with wrong mode");

  // no unused action or mode codes
  a_codes: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> ((out_action != 2'd3) && (out_mode != 3'd6) && (out_mode != 3'd7)))
    else $error("unused code on result channel");

  // a stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_action) && $stable(out_keycode) && $stable(out_mode)))
    else $error("stalled result changed");

endmodule

bind oneshot_modifier_fsm_top osm_checker u_osm_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (mod_out.valid),
  .out_ready   (mod_out.ready),
  .out_action  (mod_out.mod_action),
  .out_keycode (mod_out.mod_keycode),
  .out_mode    (mod_out.new_mode)
);

[tb/sv/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the one-shot modifier key state machine: a short
// table of hand-picked key events, then random tap, hold and use sequences
// under several trigger, modifier and lock settings, every result compared
// field by field with a behavioural model of the mode machine
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [osm_pkg::CfgIndexW-1:0] CFG_SPARE_INDEX = 2'd3;
  localparam int unsigned PHASE_EVENTS = 325;
  localparam int unsigned NUM_PHASES   = 6;
  localparam int unsigned PAUSE_EVERY  = 120;
  localparam int unsigned IDLE_PCT     = 35;

  // one row of directed stimulus: a key event or a register setting
  typedef struct {
    bit                            is_cfg;
    logic [osm_pkg::KeyCodeW-1:0]  code;
    bit                            pressed;
    bit                            cancel;
    bit                            ignored;
    bit                            typed;
    osm_pkg::action_t              t_act;
    logic [osm_pkg::KeyCodeW-1:0]  t_kc;
    logic [osm_pkg::ModeCodeW-1:0] t_mode;
    logic [osm_pkg::CfgDataW-1:0]  c_trig;
    logic [osm_pkg::CfgDataW-1:0]  c_mod;
    logic [osm_pkg::CfgDataW-1:0]  c_lock;
  } stim_row_t;

  // result awaited for one accepted key event
  typedef struct {
    osm_pkg::action_t              act;
    logic [osm_pkg::KeyCodeW-1:0]  kc;
    logic [osm_pkg::ModeCodeW-1:0] mode;
    bit                            typed;
    osm_pkg::action_t              t_act;
    logic [osm_pkg::KeyCodeW-1:0]  t_kc;
    logic [osm_pkg::ModeCodeW-1:0] t_mode;
  } mod_result_t;

  logic clk;
  logic rst;

  osm_cfg_if cfg_ch ();
  osm_key_if key_ch ();
  osm_res_if res_ch ();

  oneshot_modifier_fsm_top u_dut (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg_ch),
    .key_in  (key_ch),
    .mod_out (res_ch)
  );

  // model copy of the registers and the mode
  logic [osm_pkg::KeyCodeW-1:0]  mdl_trigger;
  logic [osm_pkg::KeyCodeW-1:0]  mdl_modifier;
  logic                          mdl_lock;
  logic [osm_pkg::ModeCodeW-1:0] mdl_mode;

  mod_result_t pending_results[$];
  stim_row_t   dir_rows[$];

  // typed expectation travelling with the request being offered
  bit                            row_typed;
  osm_pkg::action_t              row_act;
  logic [osm_pkg::KeyCodeW-1:0]  row_kc;
  logic [osm_pkg::ModeCodeW-1:0] row_mode;

  bit                           idle_on;
  logic [osm_pkg::KeyCodeW-1:0] cur_trigger;
  int unsigned                  errors;
  int unsigned                  events_sent;
  int unsigned                  results_seen;
  int unsigned                  reg_writes;

  // clock
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // overall time limit
  initial begin
    #5_000_000;
    $display("tb_top NOT OK");
    $finish;
  end

  // next mode and action for one key event
  function automatic mod_result_t predict_oneshot(
    input logic [osm_pkg::ModeCodeW-1:0] cur,
    input logic [osm_pkg::KeyCodeW-1:0]  code,
    input bit pr, input bit cn, input bit ig);
    mod_result_t r;
    logic [osm_pkg::ModeCodeW-1:0] m;
    osm_pkg::action_t a;
    m = cur;
    a = osm_pkg::ACT_NONE;
    if (code == mdl_trigger) begin
      if (pr) begin
        case (m)
          osm_pkg::CODE_UP: begin
            m = osm_pkg::CODE_DOWN_UNUSED;
            a = osm_pkg::ACT_REG;
          end
          osm_pkg::CODE_QUEUED: begin
            m = mdl_lock ? osm_pkg::CODE_LOCKED : osm_pkg::CODE_DOWN_UNUSED;
          end
          osm_pkg::CODE_LOCKED: begin
            m = osm_pkg::CODE_UP;
            a = osm_pkg::ACT_UNREG;
          end
          default: m = osm_pkg::CODE_DOWN_UNUSED;
        endcase
      end else if (m == osm_pkg::CODE_DOWN_UNUSED) begin
        m = osm_pkg::CODE_QUEUED;
      end else if (m == osm_pkg::CODE_DOWN_USED) begin
        m = osm_pkg::CODE_UP;
        a = osm_pkg::ACT_UNREG;
      end
    end else if (pr) begin
      // cancel first, then the use-up step sees the new mode
      if (cn && m != osm_pkg::CODE_UP) begin
        m = osm_pkg::CODE_UP;
        a = osm_pkg::ACT_UNREG;
      end
      if (!ig) begin
        if (m == osm_pkg::CODE_QUEUED) begin
          m = osm_pkg::CODE_QUEUED_USED;
        end else if (m == osm_pkg::CODE_QUEUED_USED) begin
          m = osm_pkg::CODE_UP;
          a = osm_pkg::ACT_UNREG;
        end
      end
    end else if (!ig) begin
      if (m == osm_pkg::CODE_DOWN_UNUSED) begin
        m = osm_pkg::CODE_DOWN_USED;
      end else if (m == osm_pkg::CODE_QUEUED || m == osm_pkg::CODE_QUEUED_USED) begin
        m = osm_pkg::CODE_UP;
        a = osm_pkg::ACT_UNREG;
      end
    end
    r.act    = a;
    r.kc     = mdl_modifier;
    r.mode   = m;
    r.typed  = 1'b0;
    r.t_act  = osm_pkg::ACT_NONE;
    r.t_kc   = '0;
    r.t_mode = osm_pkg::CODE_UP;
    return r;
  endfunction

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, what, want, got);
    end
  endtask

  // result checking, key request tracking and register tracking
  always @(posedge clk) begin
    mod_result_t want;
    mod_result_t nxt;
    if (!rst) begin
      if (res_ch.valid && res_ch.ready) begin
        if (pending_results.size() == 0) begin
          errors++;
          $display("%0t ns: result with none awaited, expected nothing actual %h/%h/%h",
                   $time, res_ch.mod_action, res_ch.mod_keycode, res_ch.new_mode);
        end else begin
          want = pending_results.pop_front();
          results_seen++;
          check_field("mod_action", 16'(want.act), 16'(res_ch.mod_action));
          check_field("mod_keycode", want.kc, res_ch.mod_keycode);
          check_field("new_mode", 16'(want.mode), 16'(res_ch.new_mode));
          if (want.typed) begin
            check_field("mod_action (table)", 16'(want.t_act), 16'(res_ch.mod_action));
            check_field("mod_keycode (table)", want.t_kc, res_ch.mod_keycode);
            check_field("new_mode (table)", 16'(want.t_mode), 16'(res_ch.new_mode));
          end
        end
      end
      if (key_ch.valid && key_ch.ready) begin
        nxt = predict_oneshot(mdl_mode, key_ch.key_code, key_ch.key_pressed,
                              key_ch.cancel_key, key_ch.ignored_key);
        nxt.typed  = row_typed;
        nxt.t_act  = row_act;
        nxt.t_kc   = row_kc;
        nxt.t_mode = row_mode;
        mdl_mode   = nxt.mode;
        pending_results.push_back(nxt);
      end
      if (cfg_ch.valid && cfg_ch.ready) begin
        reg_writes++;
        case (cfg_ch.index)
          osm_pkg::CFG_TRIGGER_CODE:  mdl_trigger  = cfg_ch.data;
          osm_pkg::CFG_MODIFIER_CODE: mdl_modifier = cfg_ch.data;
          osm_pkg::CFG_LOCK_ENABLE:   mdl_lock     = cfg_ch.data[0];
          default: ;
        endcase
      end
    end
  end

  // result side back-pressure
  always @(negedge clk) begin
    res_ch.ready <= !idle_on || ($urandom_range(99) >= IDLE_PCT);
  end

  function automatic stim_row_t ev(input logic [osm_pkg::KeyCodeW-1:0] code,
                                   input bit pr, input bit cn, input bit ig);
    stim_row_t r;
    r.is_cfg  = 1'b0;
    r.code    = code;
    r.pressed = pr;
    r.cancel  = cn;
    r.ignored = ig;
    r.typed   = 1'b0;
    r.t_act   = osm_pkg::ACT_NONE;
    r.t_kc    = '0;
    r.t_mode  = osm_pkg::CODE_UP;
    r.c_trig  = '0;
    r.c_mod   = '0;
    r.c_lock  = '0;
    return r;
  endfunction

  function automatic stim_row_t evt(input logic [osm_pkg::KeyCodeW-1:0] code,
                                    input bit pr, input bit cn, input bit ig,
                                    input osm_pkg::action_t act,
                                    input logic [osm_pkg::KeyCodeW-1:0] kc,
                                    input logic [osm_pkg::ModeCodeW-1:0] mode);
    stim_row_t r;
    r        = ev(code, pr, cn, ig);
    r.typed  = 1'b1;
    r.t_act  = act;
    r.t_kc   = kc;
    r.t_mode = mode;
    return r;
  endfunction

  function automatic stim_row_t cf(input logic [osm_pkg::CfgDataW-1:0] trig,
                                   input logic [osm_pkg::CfgDataW-1:0] modc,
                                   input logic [osm_pkg::CfgDataW-1:0] lock);
    stim_row_t r;
    r        = ev('0, 1'b0, 1'b0, 1'b0);
    r.is_cfg = 1'b1;
    r.c_trig = trig;
    r.c_mod  = modc;
    r.c_lock = lock;
    return r;
  endfunction

  // offer one key request, with random idle cycles ahead of it
  task automatic send_key(input stim_row_t r);
    @(negedge clk);
    while (idle_on && $urandom_range(99) < IDLE_PCT) begin
      key_ch.valid <= 1'b0;
      @(negedge clk);
    end
    key_ch.valid       <= 1'b1;
    key_ch.key_code    <= r.code;
    key_ch.key_pressed <= r.pressed;
    key_ch.cancel_key  <= r.cancel;
    key_ch.ignored_key <= r.ignored;
    row_typed          <= r.typed;
    row_act            <= r.t_act;
    row_kc             <= r.t_kc;
    row_mode           <= r.t_mode;
    do @(posedge clk); while (!key_ch.ready);
    events_sent++;
  endtask

  // stop offering and wait for every awaited result
  task automatic drain();
    @(negedge clk);
    key_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [osm_pkg::CfgIndexW-1:0] idx,
                           input logic [osm_pkg::CfgDataW-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    do @(posedge clk); while (!cfg_ch.ready);
  endtask

  // full register setting, including a write to the unused index
  task automatic write_config(input logic [osm_pkg::CfgDataW-1:0] trig,
                              input logic [osm_pkg::CfgDataW-1:0] modc,
                              input logic [osm_pkg::CfgDataW-1:0] lock);
    cfg_write(CFG_SPARE_INDEX, 16'($urandom));
    cfg_write(osm_pkg::CFG_TRIGGER_CODE, trig);
    cfg_write(osm_pkg::CFG_MODIFIER_CODE, modc);
    cfg_write(osm_pkg::CFG_LOCK_ENABLE, lock);
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
    cur_trigger = trig;
  endtask

  function automatic logic [osm_pkg::KeyCodeW-1:0] other_code();
    logic [osm_pkg::KeyCodeW-1:0] c;
    c = 16'($urandom);
    if (c == cur_trigger) c = c ^ 16'h0001;
    return c;
  endfunction

  // one short key sequence with random content
  task automatic play_burst();
    logic [osm_pkg::KeyCodeW-1:0] oc;
    int unsigned pick;
    int unsigned n;
    pick = $urandom_range(99);
    oc   = other_code();
    if (pick < 20) begin
      // tap of the trigger
      send_key(ev(cur_trigger, 1'b1, 1'($urandom), 1'($urandom)));
      send_key(ev(cur_trigger, 1'b0, 1'($urandom), 1'($urandom)));
    end else if (pick < 35) begin
      // double tap, the lock path when enabled
      repeat (2) begin
        send_key(ev(cur_trigger, 1'b1, 1'($urandom), 1'($urandom)));
        send_key(ev(cur_trigger, 1'b0, 1'($urandom), 1'($urandom)));
      end
    end else if (pick < 55) begin
      // trigger held while another key is used
      send_key(ev(cur_trigger, 1'b1, 1'($urandom), 1'($urandom)));
      send_key(ev(oc, 1'b1, $urandom_range(99) < 15, $urandom_range(99) < 20));
      send_key(ev(oc, 1'b0, $urandom_range(99) < 15, $urandom_range(99) < 20));
      send_key(ev(cur_trigger, 1'b0, 1'($urandom), 1'($urandom)));
    end else if (pick < 75) begin
      // tap, then the queued modifier is used by another key
      send_key(ev(cur_trigger, 1'b1, 1'($urandom), 1'($urandom)));
      send_key(ev(cur_trigger, 1'b0, 1'($urandom), 1'($urandom)));
      send_key(ev(oc, 1'b1, $urandom_range(99) < 15, $urandom_range(99) < 20));
      send_key(ev(oc, 1'b0, $urandom_range(99) < 15, $urandom_range(99) < 20));
    end else if (pick < 87) begin
      // plain key stroke
      send_key(ev(oc, 1'b1, $urandom_range(99) < 15, $urandom_range(99) < 20));
      send_key(ev(oc, 1'b0, $urandom_range(99) < 15, $urandom_range(99) < 20));
    end else begin
      // noise
      n = $urandom_range(3, 1);
      repeat (n) begin
        oc = ($urandom_range(99) < 30) ? cur_trigger : 16'($urandom);
        send_key(ev(oc, 1'($urandom), 1'($urandom), 1'($urandom)));
      end
    end
  endtask

  // main sequence
  initial begin
    logic [osm_pkg::CfgDataW-1:0] p_trig;
    logic [osm_pkg::CfgDataW-1:0] p_mod;
    logic [osm_pkg::CfgDataW-1:0] p_lock;
    int unsigned phase_start;
    int unsigned next_pause;

    rst                = 1'b1;
    idle_on            = 1'b1;
    errors             = 0;
    events_sent        = 0;
    results_seen       = 0;
    reg_writes         = 0;
    cur_trigger        = '0;
    mdl_trigger        = '0;
    mdl_modifier       = '0;
    mdl_lock           = 1'b0;
    mdl_mode           = osm_pkg::CODE_UP;
    row_typed          = 1'b0;
    row_act            = osm_pkg::ACT_NONE;
    row_kc             = '0;
    row_mode           = osm_pkg::CODE_UP;
    key_ch.valid       = 1'b0;
    key_ch.key_code    = '0;
    key_ch.key_pressed = 1'b0;
    key_ch.cancel_key  = 1'b0;
    key_ch.ignored_key = 1'b0;
    cfg_ch.valid       = 1'b0;
    cfg_ch.index       = '0;
    cfg_ch.data        = '0;
    res_ch.ready       = 1'b0;

    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed table, first under the reset setting (trigger 0, modifier 0)
    dir_rows.push_back(evt(16'hFFFF, 1'b0, 1'b0, 1'b0, osm_pkg::ACT_NONE, 16'h0000,
                           osm_pkg::CODE_UP));
    dir_rows.push_back(evt(16'h0000, 1'b1, 1'b0, 1'b0, osm_pkg::ACT_REG, 16'h0000,
                           osm_pkg::CODE_DOWN_UNUSED));
    dir_rows.push_back(ev(16'h0000, 1'b1, 1'b0, 1'b0));  // trigger pressed while held
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));  // trigger release while queued
    dir_rows.push_back(ev(16'h1234, 1'b1, 1'b0, 1'b1));  // ignored key press
    dir_rows.push_back(ev(16'h1234, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));  // release while queued used
    dir_rows.push_back(evt(16'h1234, 1'b1, 1'b0, 1'b0, osm_pkg::ACT_UNREG, 16'h0000,
                           osm_pkg::CODE_UP));
    dir_rows.push_back(ev(16'h0000, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0055, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b1, 1'b0, 1'b0));  // press while down used
    dir_rows.push_back(ev(16'h0055, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0077, 1'b1, 1'b1, 1'b0));  // cancel with nothing pending
    // extremes, lock on with stray upper data bits
    dir_rows.push_back(cf(16'hFFFF, 16'hFFFF, 16'hFFFF));
    dir_rows.push_back(evt(16'hFFFF, 1'b1, 1'b1, 1'b1, osm_pkg::ACT_REG, 16'hFFFF,
                           osm_pkg::CODE_DOWN_UNUSED));
    dir_rows.push_back(ev(16'hFFFF, 1'b0, 1'b1, 1'b1));
    dir_rows.push_back(ev(16'hFFFF, 1'b1, 1'b0, 1'b0));  // second tap locks
    dir_rows.push_back(ev(16'h0000, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b1, 1'b1, 1'b1));  // cancel and ignored in locked
    dir_rows.push_back(ev(16'hFFFF, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'hFFFF, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b1));  // ignored release while queued
    dir_rows.push_back(ev(16'h0000, 1'b0, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'hFFFF, 1'b1, 1'b0, 1'b0));
    dir_rows.push_back(ev(16'hFFFF, 1'b1, 1'b0, 1'b0));  // trigger pressed again while held
    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        drain();
        write_config(dir_rows[i].c_trig, dir_rows[i].c_mod, dir_rows[i].c_lock);
      end else begin
        send_key(dir_rows[i]);
      end
    end

    // random phases, one register setting each
    for (int unsigned ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      case (ph)
        0: begin
          p_trig = 16'($urandom); p_mod = 16'($urandom); p_lock = 16'($urandom) | 16'h1;
        end
        1: begin p_trig = 16'h0000; p_mod = 16'hFFFF; p_lock = 16'($urandom) & 16'hFFFE; end
        2: begin p_trig = 16'hFFFF; p_mod = 16'h0000; p_lock = 16'h0001; end
        3: begin p_trig = 16'($urandom); p_mod = 16'($urandom); p_lock = 16'h0000; end
        4: begin p_trig = 16'($urandom); p_mod = 16'($urandom); p_lock = 16'hFFFF; end
        default: begin
          p_trig = 16'($urandom); p_mod = 16'($urandom); p_lock = 16'($urandom);
        end
      endcase
      write_config(p_trig, p_mod, p_lock);
      // one phase runs without any idling on either side
      idle_on     = (ph != 4);
      phase_start = events_sent;
      next_pause  = PAUSE_EVERY;
      while (events_sent - phase_start < PHASE_EVENTS) begin
        play_burst();
        if (events_sent - phase_start >= next_pause) begin
          drain();
          next_pause += PAUSE_EVERY;
        end
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      errors++;
      $display("%0t ns: %0d results never arrived, expected 0 actual %0d", $time,
               pending_results.size(), pending_results.size());
    end

    $display("run covered %0d key events over %0d register settings plus the table",
             events_sent, NUM_PHASES);
    $display("%0d results checked, %0d register writes, %0d mismatches",
             results_seen, reg_writes, errors);
    if (errors == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end

endmodule

[sim.f]
design/osm_pkg.sv
design/osm_if.sv
design/osm_step.sv
design/oneshot_modifier_fsm_top.sv
design/osm_checker.sv
tb/sv/tb_top.sv
